### design/srst_pkg.sv
// Shared types, token codes and constants for the speech-token sequencer.
`default_nettype none
package srst_pkg;

    typedef struct packed {
        logic [3:0]  operation;
        logic signed [15:0] temperature_hundredths;
        logic [15:0] humidity_hundredths;
        logic [19:0] light_tenths;
        logic [15:0] co2_ppm;
        logic [15:0] voc_ppb;
        logic [7:0]  hour_value;
        logic [7:0]  minute_value;
        logic [7:0]  second_value;
    } t_req;

    typedef struct packed {
        logic [5:0] clip_token;
        logic       last_token;
        logic [1:0] error_code;
    } t_tok;

    localparam logic [5:0] TK_TEN = 6'd10, TK_HUNDRED = 6'd11, TK_THOUSAND = 6'd12,
        TK_WAN = 6'd13, TK_POINT = 6'd14, TK_CUE = 6'd15, TK_SILENCE = 6'd16,
        TK_LOW_WARN = 6'd17, TK_HIGH_WARN = 6'd18, TK_TEMP_IS = 6'd19,
        TK_BELOW = 6'd20, TK_DEGC = 6'd21, TK_HUM_IS = 6'd22, TK_PERCENT = 6'd23,
        TK_LIGHT_IS = 6'd24, TK_LUX = 6'd25, TK_TIME_IS = 6'd26, TK_HOUR = 6'd27,
        TK_MINUTE = 6'd28, TK_SECOND = 6'd29, TK_GOAL_DUE = 6'd30,
        TK_CO2_INTRO = 6'd31, TK_PPM = 6'd32, TK_VOC_INTRO = 6'd33, TK_PPB = 6'd34;

    localparam logic [1:0] ERR_OK = 2'd0, ERR_RANGE = 2'd1, ERR_KIND = 2'd2;

    localparam logic [3:0] OP_TEMP = 4'd0, OP_HUM = 4'd1, OP_BOTH = 4'd2,
        OP_LIGHT = 4'd3, OP_AIR = 4'd4, OP_LOW = 4'd5, OP_HIGH = 4'd6, OP_TIME = 4'd7;

    // Classified command handed from front to back.
    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  err;
        logic        neg;
        logic [15:0] val_a;   // temp magnitude / humidity / light int / co2 / hour
        logic [3:0]  frac_a;  // light tenth digit
        logic [15:0] val_b;   // humidity / voc / minute
        logic [5:0]  val_c;   // second
    } t_cmd;

    localparam int QDEPTH = 2;
    localparam int QAW = $clog2(QDEPTH);

endpackage
`default_nettype wire

### design/srst_front.sv
// Front end: range checks and value split of one request.
`default_nettype none
module srst_front
    import srst_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  wire  i_ready,
    output t_cmd o_cmd
);
    logic r_full;
    t_cmd r_cmd, n_cmd;
    logic signed [16:0] temp;
    logic [16:0] tmag;
    logic [16:0] lq;   // light / 10 via reciprocal
    logic [39:0] lprod;
    logic [19:0] lrem;

    assign o_ready = !r_full || i_ready;
    assign o_valid = r_full;
    assign o_cmd = r_cmd;

    always_comb begin
        temp = 17'(i_req.temperature_hundredths);
        tmag = temp[16] ? 17'(-temp) : 17'(temp);
        // 2^23/10 rounded up: exact quotient over the full 20-bit range
        lprod = 40'(i_req.light_tenths) * 40'd838861;
        lq = lprod[39:23];
        lrem = i_req.light_tenths - 20'(20'(lq) * 20'd10);
        n_cmd = '0;
        n_cmd.kind = i_req.operation;
        n_cmd.err = ERR_OK;
        n_cmd.neg = temp[16];
        n_cmd.val_b = i_req.humidity_hundredths;
        case (i_req.operation)
            OP_TEMP, OP_BOTH: n_cmd.val_a = tmag[15:0];
            OP_HUM:   n_cmd.val_a = i_req.humidity_hundredths;
            OP_LIGHT: begin
                n_cmd.val_a = lq[15:0];
                n_cmd.frac_a = lrem[3:0];
            end
            OP_AIR: begin
                n_cmd.val_a = i_req.co2_ppm;
                n_cmd.val_b = i_req.voc_ppb;
            end
            OP_TIME: begin
                n_cmd.val_a = 16'(i_req.hour_value);
                n_cmd.val_b = 16'(i_req.minute_value);
                n_cmd.val_c = i_req.second_value[5:0];
            end
            default: ;
        endcase
        if (i_req.operation > OP_TIME) n_cmd.err = ERR_KIND;
        else if ((i_req.operation == OP_TEMP || i_req.operation == OP_BOTH) &&
                 (temp < -17'sd4500 || temp > 17'sd13000)) n_cmd.err = ERR_RANGE;
        else if ((i_req.operation == OP_HUM || i_req.operation == OP_BOTH) &&
                 i_req.humidity_hundredths > 16'd10000) n_cmd.err = ERR_RANGE;
        else if (i_req.operation == OP_LIGHT && lq > 17'd65535) n_cmd.err = ERR_RANGE;
        else if (i_req.operation == OP_TIME && (i_req.hour_value > 8'd23 ||
                 i_req.minute_value > 8'd59 || i_req.second_value > 8'd59))
            n_cmd.err = ERR_RANGE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
        if (o_ready && i_valid) r_cmd <= n_cmd;
    end
endmodule
`default_nettype wire

### design/srst_queue.sv
// Short command queue between front and back.
`default_nettype none
module srst_queue
    import srst_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  wire  i_ready,
    output t_cmd o_cmd
);
    t_cmd r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != (QAW+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

### design/srst_back.sv
// Back end: token sequencer that speaks one command per pass.
`default_nettype none
module srst_back
    import srst_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  wire  i_ready,
    output t_tok o_tok
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_RUN = 4'b0010, S_SPLIT = 4'b0100, S_NUM = 4'b1000
    } t_state;

    // Script codes: 0..34 token, 40+slot integer, 48+slot hundredths,
    // SC_FRAC the light tenth digit, SC_END end of script.
    localparam logic [5:0] SC_INT = 6'd40, SC_HUN = 6'd48, SC_FRAC = 6'd56, SC_END = 6'd63;
    localparam logic [5:0] TK_LIMIT = 6'd35;

    // Speaking positions inside one number, walked in order.
    localparam logic [4:0] P_NEG = 5'd0, P_ZERO = 5'd1, P_WAN = 5'd2, P_WANU = 5'd3,
        P_TH = 5'd4, P_THU = 5'd5, P_HU0 = 5'd6, P_HU = 5'd7, P_HUU = 5'd8,
        P_TE0 = 5'd9, P_TE = 5'd10, P_TEU = 5'd11, P_ON0 = 5'd12, P_ON = 5'd13,
        P_PNT = 5'd14, P_F1 = 5'd15, P_F2 = 5'd16;

    function automatic logic [5:0] script(input logic [3:0] k, input logic [4:0] pc);
        logic [5:0] s;
        s = SC_END;
        if (pc == 5'd0) s = TK_CUE;
        else if (pc == 5'd1) s = TK_SILENCE;
        else begin
            case (k)
                OP_TEMP, OP_BOTH: begin
                    case (pc)
                        5'd2: s = TK_TEMP_IS;
                        5'd3: s = SC_HUN;
                        5'd4: s = TK_DEGC;
                        5'd5: s = (k == OP_BOTH) ? TK_SILENCE : SC_END;
                        5'd6: s = TK_HUM_IS;
                        5'd7: s = SC_HUN + 6'd1;
                        5'd8: s = TK_PERCENT;
                        default: s = SC_END;
                    endcase
                end
                OP_HUM: begin
                    case (pc)
                        5'd2: s = TK_HUM_IS;
                        5'd3: s = SC_HUN;
                        5'd4: s = TK_PERCENT;
                        default: s = SC_END;
                    endcase
                end
                OP_LIGHT: begin
                    case (pc)
                        5'd2: s = TK_LIGHT_IS;
                        5'd3: s = SC_INT;
                        5'd4: s = TK_POINT;
                        5'd5: s = SC_FRAC;
                        5'd6: s = TK_LUX;
                        default: s = SC_END;
                    endcase
                end
                OP_AIR: begin
                    case (pc)
                        5'd2: s = TK_CO2_INTRO;
                        5'd3: s = SC_INT;
                        5'd4: s = TK_PPM;
                        5'd5: s = TK_SILENCE;
                        5'd6: s = TK_VOC_INTRO;
                        5'd7: s = SC_INT + 6'd1;
                        5'd8: s = TK_PPB;
                        default: s = SC_END;
                    endcase
                end
                OP_LOW: s = (pc == 5'd2) ? TK_LOW_WARN : SC_END;
                OP_HIGH: s = (pc == 5'd2) ? TK_HIGH_WARN : SC_END;
                default: begin
                    case (pc)
                        5'd2: s = TK_TIME_IS;
                        5'd3: s = SC_INT;
                        5'd4: s = TK_HOUR;
                        5'd5: s = SC_INT + 6'd1;
                        5'd6: s = TK_MINUTE;
                        5'd7: s = SC_INT + 6'd2;
                        5'd8: s = TK_SECOND;
                        5'd9: s = TK_SILENCE;
                        5'd10: s = TK_GOAL_DUE;
                        default: s = SC_END;
                    endcase
                end
            endcase
        end
        return s;
    endfunction

    t_state      r_state;
    t_cmd        r_cmd;
    logic [4:0]  r_pc;
    logic [3:0]  r_dig [5];   // digits of current number: wan..one
    logic [2:0]  r_step;      // digit-split counter
    logic [4:0]  r_pos;       // speaking position
    logic [15:0] r_work;
    logic        r_hun, r_neg, r_gap;
    logic        r_ov;
    t_tok        r_out;

    logic [5:0]  sc, sc_nx;
    logic [15:0] slot;
    logic        out_free;
    logic [31:0] prod;
    logic [12:0] quo;
    logic [3:0]  dig;
    logic [3:0]  wan, th, hu, te, on, f1, f2;
    logic        int_zero, big;
    logic        sp_emit, sp_gap;
    logic [5:0]  sp_tok;
    logic        e_valid, e_last;
    logic [5:0]  e_tok;
    logic [1:0]  e_err;
    logic        step_ok;

    assign o_valid = r_ov;
    assign o_tok = r_out;
    assign o_ready = r_state == S_IDLE;
    assign out_free = !r_ov || i_ready;
    assign sc = script(r_cmd.kind, r_pc);
    assign sc_nx = script(r_cmd.kind, r_pc + 5'd1);

    always_comb begin
        case (sc[2:0])
            3'd0: slot = r_cmd.val_a;
            3'd1: slot = r_cmd.val_b;
            3'd2: slot = 16'(r_cmd.val_c);
            default: slot = '0;
        endcase
    end

    // one decimal digit per cycle: exact /10 by reciprocal for 0..65535
    always_comb begin
        prod = 32'(r_work) * 32'd52429;
        quo = prod[31:19];
        dig = 4'(r_work - 16'(16'(quo) * 16'd10));
    end

    // hundredths: integer part sits two places up, fraction in the low digits
    always_comb begin
        if (r_hun) begin
            wan = 4'd0; th = 4'd0;
            hu = r_dig[0]; te = r_dig[1]; on = r_dig[2];
            f1 = r_dig[3]; f2 = r_dig[4];
        end else begin
            wan = r_dig[0]; th = r_dig[1]; hu = r_dig[2]; te = r_dig[3]; on = r_dig[4];
            f1 = 4'd0; f2 = 4'd0;
        end
        int_zero = (wan | th | hu | te | on) == 4'd0;
        big = (wan | th | hu) != 4'd0;
    end

    // speaking: each position may give one token; gap marks a skipped place
    always_comb begin
        sp_emit = 1'b0;
        sp_tok = '0;
        sp_gap = r_gap;
        case (r_pos)
            P_NEG: if (r_neg) begin sp_emit = 1'b1; sp_tok = TK_BELOW; end
            P_ZERO: if (int_zero) begin sp_emit = 1'b1; sp_tok = 6'd0; end
            P_WAN: if (wan != 4'd0) begin sp_emit = 1'b1; sp_tok = 6'(wan); end
            P_WANU: if (wan != 4'd0) begin
                sp_emit = 1'b1; sp_tok = TK_WAN; sp_gap = th == 4'd0;
            end
            P_TH: if (th != 4'd0) begin sp_emit = 1'b1; sp_tok = 6'(th); end
            P_THU: if (th != 4'd0) begin
                sp_emit = 1'b1; sp_tok = TK_THOUSAND; sp_gap = hu == 4'd0;
            end
            P_HU0: if (hu != 4'd0 && r_gap) begin sp_emit = 1'b1; sp_tok = 6'd0; end
            P_HU: if (hu != 4'd0) begin sp_emit = 1'b1; sp_tok = 6'(hu); end
            P_HUU: if (hu != 4'd0) begin
                sp_emit = 1'b1; sp_tok = TK_HUNDRED; sp_gap = te == 4'd0;
            end
            P_TE0: if (te != 4'd0 && r_gap) begin sp_emit = 1'b1; sp_tok = 6'd0; end
            // bare "ten" for 10..19
            P_TE: if (te > 4'd1 || (te != 4'd0 && big)) begin
                sp_emit = 1'b1; sp_tok = 6'(te);
            end
            P_TEU: if (te != 4'd0) begin
                sp_emit = 1'b1; sp_tok = TK_TEN; sp_gap = 1'b0;
            end
            P_ON0: if (on != 4'd0 && r_gap) begin sp_emit = 1'b1; sp_tok = 6'd0; end
            P_ON: if (on != 4'd0) begin sp_emit = 1'b1; sp_tok = 6'(on); end
            P_PNT: if (r_hun) begin sp_emit = 1'b1; sp_tok = TK_POINT; end
            P_F1: if (r_hun) begin sp_emit = 1'b1; sp_tok = 6'(f1); end
            default: if (r_hun) begin sp_emit = 1'b1; sp_tok = 6'(f2); end
        endcase
    end

    // token into the output register; only a script token or the error token can be the last one
    always_comb begin
        e_valid = 1'b0;
        e_tok = '0;
        e_last = 1'b0;
        e_err = ERR_OK;
        case (r_state)
            S_RUN: begin
                if (r_cmd.err != ERR_OK) begin
                    e_valid = out_free;
                    e_last = 1'b1;
                    e_err = r_cmd.err;
                end else if (sc < TK_LIMIT) begin
                    e_valid = out_free;
                    e_tok = sc;
                    e_last = sc_nx == SC_END;
                end else if (sc == SC_FRAC) begin
                    e_valid = out_free;
                    e_tok = 6'(r_cmd.frac_a);
                end
            end
            S_NUM: begin
                e_valid = sp_emit && out_free;
                e_tok = sp_tok;
            end
            default: ;
        endcase
        step_ok = !sp_emit || out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (e_valid) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_pc <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (e_valid) begin
                        r_pc <= r_pc + 5'd1;
                        if (e_last) r_state <= S_IDLE;
                    end else if (sc == SC_END) begin
                        r_state <= S_IDLE;
                    end else if (r_cmd.err == ERR_OK && sc >= SC_INT && sc != SC_FRAC) begin
                        r_work <= slot;
                        r_hun <= sc[5:3] == SC_HUN[5:3];
                        r_neg <= (r_cmd.kind == OP_TEMP || r_cmd.kind == OP_BOTH) &&
                                 sc == SC_HUN && r_cmd.neg;
                        r_step <= '0;
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    // ones digit first, five steps
                    r_dig[3'(3'd4 - r_step)] <= dig;
                    r_work <= 16'(quo);
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd4) begin
                        r_pos <= P_NEG;
                        r_gap <= 1'b0;
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    if (step_ok) begin
                        r_gap <= sp_gap;
                        if (r_pos == P_F2) begin
                            r_pc <= r_pc + 5'd1;
                            r_state <= S_RUN;
                        end else begin
                            r_pos <= r_pos + 5'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (e_valid) r_out <= '{clip_token: e_tok, last_token: e_last, error_code: e_err};
    end
endmodule
`default_nettype wire

### design/sensor_reading_to_speech_tokens.sv
// Top level of the sensor-reading speech-token sequencer.
`default_nettype none
// One request in, a run of voice-clip tokens out, last one flagged; a bad kind or
// out-of-range reading gives a single error token. The front end checks ranges and
// splits values, a two-entry queue decouples it from the back end, which walks a
// per-kind script and speaks numbers digit by digit. The back end sets the rate: it
// takes a command only while idle, then gives each fixed token and speaks each number
// by loading it, splitting off its digits and walking its speaking positions; a token
// that the receiver holds off stalls it. Front and queue hold up to three more
// requests while the back end is busy.
module sensor_reading_to_speech_tokens
    import srst_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  wire  i_ready,
    output t_tok o_tok
);
    logic f_valid, f_ready, q_valid, q_ready;
    t_cmd f_cmd, q_cmd;

    // classify the request
    srst_front u_front (.i_clk, .i_rst_n, .i_valid, .o_ready, .i_req,
        .o_valid(f_valid), .i_ready(f_ready), .o_cmd(f_cmd));

    // command queue
    srst_queue u_queue (.i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready),
        .i_cmd(f_cmd), .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd));

    // token sequencer
    srst_back u_back (.i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .o_valid, .i_ready, .o_tok);
endmodule
`default_nettype wire

### verif/sensor_reading_to_speech_tokens_tb.sv
// Testbench for the speech-token sequencer: random and directed requests, token-level check.
module sensor_reading_to_speech_tokens_tb;
    import srst_pkg::*;

    // Holds the spoken-token stream each accepted request should produce.
    class token_scoreboard;
        t_tok pending_tokens[$];
        int   err_count;
        int   tok_seen;
        int   req_seen;

        function void put_tok(logic [5:0] t, logic [1:0] e);
            t_tok x;
            x.clip_token = t;
            x.last_token = 1'b0;
            x.error_code = e;
            pending_tokens.push_back(x);
        endfunction

        // Chinese-style reading of 0..65535.
        function void speak_integer(int unsigned v);
            int unsigned wan, th, hu, te, on;
            bit gap;
            gap = 0;
            if (v == 0) begin
                put_tok(6'd0, ERR_OK);
                return;
            end
            wan = v / 10000;
            th = (v / 1000) % 10;
            hu = (v / 100) % 10;
            te = (v / 10) % 10;
            on = v % 10;
            if (wan > 0) begin
                put_tok(wan[5:0], ERR_OK);
                put_tok(TK_WAN, ERR_OK);
                gap = (th == 0);
            end
            if (th > 0) begin
                put_tok(th[5:0], ERR_OK);
                put_tok(TK_THOUSAND, ERR_OK);
                gap = (hu == 0);
            end
            if (hu > 0) begin
                if (gap) put_tok(6'd0, ERR_OK);
                put_tok(hu[5:0], ERR_OK);
                put_tok(TK_HUNDRED, ERR_OK);
                gap = (te == 0);
            end
            if (te > 0) begin
                if (gap) put_tok(6'd0, ERR_OK);
                if (te > 1 || v >= 100) put_tok(te[5:0], ERR_OK);
                put_tok(TK_TEN, ERR_OK);
                gap = 0;
            end
            if (on > 0) begin
                if (gap) put_tok(6'd0, ERR_OK);
                put_tok(on[5:0], ERR_OK);
            end
        endfunction

        function void speak_hundredths(int unsigned v);
            speak_integer(v / 100);
            put_tok(TK_POINT, ERR_OK);
            put_tok(6'((v % 100) / 10), ERR_OK);
            put_tok(6'(v % 10), ERR_OK);
        endfunction

        function void speak_humidity(int unsigned h);
            put_tok(TK_HUM_IS, ERR_OK);
            speak_hundredths(h);
            put_tok(TK_PERCENT, ERR_OK);
        endfunction

        function void note_request(t_req r);
            int          temp;
            int unsigned hum, mag, first_idx;
            logic [1:0]  bad;
            req_seen++;
            first_idx = pending_tokens.size();
            temp = r.temperature_hundredths;
            hum = r.humidity_hundredths;
            bad = ERR_OK;
            if (r.operation > OP_TIME) bad = ERR_KIND;
            else if ((r.operation == OP_TEMP || r.operation == OP_BOTH) &&
                     (temp < -4500 || temp > 13000)) bad = ERR_RANGE;
            else if ((r.operation == OP_HUM || r.operation == OP_BOTH) && hum > 10000)
                bad = ERR_RANGE;
            else if (r.operation == OP_LIGHT && r.light_tenths / 10 > 65535) bad = ERR_RANGE;
            else if (r.operation == OP_TIME && (r.hour_value > 23 || r.minute_value > 59 ||
                     r.second_value > 59)) bad = ERR_RANGE;
            if (bad != ERR_OK) begin
                put_tok(6'd0, bad);
            end else begin
                put_tok(TK_CUE, ERR_OK);
                put_tok(TK_SILENCE, ERR_OK);
                case (r.operation)
                    OP_TEMP, OP_BOTH: begin
                        mag = (temp < 0) ? -temp : temp;
                        put_tok(TK_TEMP_IS, ERR_OK);
                        if (temp < 0) put_tok(TK_BELOW, ERR_OK);
                        speak_hundredths(mag);
                        put_tok(TK_DEGC, ERR_OK);
                        if (r.operation == OP_BOTH) begin
                            put_tok(TK_SILENCE, ERR_OK);
                            speak_humidity(hum);
                        end
                    end
                    OP_HUM: speak_humidity(hum);
                    OP_LIGHT: begin
                        put_tok(TK_LIGHT_IS, ERR_OK);
                        speak_integer(r.light_tenths / 10);
                        put_tok(TK_POINT, ERR_OK);
                        put_tok(6'(r.light_tenths % 10), ERR_OK);
                        put_tok(TK_LUX, ERR_OK);
                    end
                    OP_AIR: begin
                        put_tok(TK_CO2_INTRO, ERR_OK);
                        speak_integer(r.co2_ppm);
                        put_tok(TK_PPM, ERR_OK);
                        put_tok(TK_SILENCE, ERR_OK);
                        put_tok(TK_VOC_INTRO, ERR_OK);
                        speak_integer(r.voc_ppb);
                        put_tok(TK_PPB, ERR_OK);
                    end
                    OP_LOW: put_tok(TK_LOW_WARN, ERR_OK);
                    OP_HIGH: put_tok(TK_HIGH_WARN, ERR_OK);
                    default: begin
                        put_tok(TK_TIME_IS, ERR_OK);
                        speak_integer(r.hour_value);
                        put_tok(TK_HOUR, ERR_OK);
                        speak_integer(r.minute_value);
                        put_tok(TK_MINUTE, ERR_OK);
                        speak_integer(r.second_value);
                        put_tok(TK_SECOND, ERR_OK);
                        put_tok(TK_SILENCE, ERR_OK);
                        put_tok(TK_GOAL_DUE, ERR_OK);
                    end
                endcase
            end
            // the sequence is capped at 25 tokens
            while (pending_tokens.size() - first_idx > 25) void'(pending_tokens.pop_back());
            pending_tokens[pending_tokens.size() - 1].last_token = 1'b1;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH token %0d: %s", tok_seen, msg);
            err_count++;
        endtask

        task check_token(t_tok got);
            t_tok want;
            tok_seen++;
            if (pending_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token %0d", got.clip_token));
                return;
            end
            want = pending_tokens.pop_front();
            if (got.clip_token !== want.clip_token)
                report_mismatch($sformatf("clip_token got %0d want %0d",
                    got.clip_token, want.clip_token));
            if (got.last_token !== want.last_token)
                report_mismatch($sformatf("last_token got %0b want %0b",
                    got.last_token, want.last_token));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("error_code got %0d want %0d",
                    got.error_code, want.error_code));
        endtask
    endclass

    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    logic i_clk, i_rst_n, i_valid, i_ready, o_ready, o_valid;
    t_req i_req;
    t_tok o_tok;

    token_scoreboard sb;
    bit  hold_req = 1'b0;   // receiver long stall request
    bit  hold_done = 1'b0;
    int  hold_count = 0;
    bit  quiet_mode;        // no idling stretch
    int  idle_count = 0;
    bit  timed_out = 1'b0;

    sensor_reading_to_speech_tokens u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_tok(o_tok)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Predict on request accept, check on token accept, both at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_request(i_req);
        if (i_rst_n && o_valid && i_ready) sb.check_token(o_tok);
    end

    // Receiver: random stalls, one long hold-off when asked.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_count <= hold_count + 1;
            if (hold_count + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    // Watchdog: cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count > WATCHDOG_LIMIT) timed_out <= 1'b1;
    end

    function automatic t_req random_request(bit shaped);
        t_req r;
        r = {$urandom, $urandom, $urandom, $urandom};
        r.operation = $urandom_range(99) < 90 ? 4'($urandom_range(OP_TIME)) : r.operation;
        if (shaped) begin
            // mostly in-range readings, with small numbers common
            r.temperature_hundredths = 16'($urandom_range(17500) - 4500);
            r.humidity_hundredths = 16'($urandom_range(10000));
            r.light_tenths = $urandom_range(1) ? 20'($urandom_range(655359)) :
                                                 20'($urandom_range(300));
            if ($urandom_range(1)) r.co2_ppm = 16'($urandom_range(120));
            if ($urandom_range(1)) r.voc_ppb = 16'($urandom_range(20000));
            r.hour_value = 8'($urandom_range(23));
            r.minute_value = 8'($urandom_range(59));
            r.second_value = 8'($urandom_range(59));
        end
        return r;
    endfunction

    // Valid stays high after the accept; wait_drained, or a gap in the next call, lowers it.
    task send_request(t_req r, bit gaps);
        while (gaps && !quiet_mode && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task send_fields(logic [3:0] op, int t, int h, int l, int c, int v,
                     int hr, int mi, int se);
        t_req r;
        r = {op, 16'(t), 16'(h), 20'(l), 16'(c), 16'(v), 8'(hr), 8'(mi), 8'(se)};
        send_request(r, 1'b1);
    endtask

    task wait_drained();
        i_valid <= 1'b0;
        while (sb.pending_tokens.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        quiet_mode = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                // directed: every kind, field extremes, error paths
                send_fields(OP_TEMP, -4500, 0, 0, 0, 0, 0, 0, 0);
                send_fields(OP_TEMP, 13000, 0, 0, 0, 0, 0, 0, 0);
                send_fields(OP_TEMP, -5, 0, 0, 0, 0, 0, 0, 0);      // below zero, zero int
                send_fields(OP_TEMP, -4501, 0, 0, 0, 0, 0, 0, 0);
                send_fields(OP_TEMP, 13001, 0, 0, 0, 0, 0, 0, 0);
                send_fields(OP_TEMP, -32768, 0, 0, 0, 0, 0, 0, 0);
                send_fields(OP_HUM, 32767, 10000, 0, 0, 0, 0, 0, 0); // unused field unchecked
                send_fields(OP_HUM, 0, 10001, 0, 0, 0, 0, 0, 0);
                send_fields(OP_BOTH, 1234, 65535, 0, 0, 0, 0, 0, 0);
                send_fields(OP_BOTH, -1010, 9909, 0, 0, 0, 0, 0, 0);
                send_fields(OP_LIGHT, 0, 0, 655359, 0, 0, 0, 0, 0);
                send_fields(OP_LIGHT, 0, 0, 655360, 0, 0, 0, 0, 0);
                send_fields(OP_LIGHT, 0, 0, 1048575, 0, 0, 0, 0, 0);
                send_fields(OP_LIGHT, 0, 0, 105, 0, 0, 0, 0, 0);    // bare ten
                send_fields(OP_AIR, 0, 0, 0, 65535, 0, 0, 0, 0);
                send_fields(OP_AIR, 0, 0, 0, 10001, 10010, 0, 0, 0);
                send_fields(OP_AIR, 0, 0, 0, 110, 1001, 0, 0, 0);
                send_fields(OP_LOW, 0, 0, 0, 0, 0, 255, 255, 255);
                send_fields(OP_HIGH, 0, 0, 0, 0, 0, 0, 0, 0);
                send_fields(OP_TIME, 0, 0, 0, 0, 0, 23, 59, 59);
                send_fields(OP_TIME, 0, 0, 0, 0, 0, 24, 0, 0);
                send_fields(OP_TIME, 0, 0, 0, 0, 0, 0, 60, 0);
                send_fields(OP_TIME, 0, 0, 0, 0, 0, 0, 0, 255);
                send_fields(4'd8, 0, 0, 0, 0, 0, 0, 0, 0);
                send_fields(4'd15, 0, 0, 0, 0, 0, 0, 0, 0);

                // sender pauses until every token has arrived
                wait_drained();
                // receiver stalls long while requests keep coming
                hold_req = 1'b1;
                repeat (8) send_request(random_request(1'b1), 1'b0);
                wait_drained();

                for (int i = 0; i < 440 && !timed_out; i++) begin
                    quiet_mode = (i >= 200 && i < 260);
                    send_request(random_request($urandom_range(99) < 80), 1'b1);
                end
                quiet_mode = 1'b0;
                wait_drained();
                repeat (60) @(posedge i_clk);
            end
            begin
                wait (timed_out);
            end
        join_any

        $display("Ran %0d requests (all kinds, range and kind errors) giving %0d tokens,",
                 sb.req_seen, sb.tok_seen);
        $display("with random stalls, a long receiver hold-off and a drained pause.");
        if (timed_out) begin
            $display("timeout: no handshake for too long");
            $display("simulation failed");
        end else if (sb.err_count == 0 && sb.pending_tokens.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d tokens missing", sb.err_count,
                     sb.pending_tokens.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule
